// File: sv/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg - shared types and constants of the polyphonic sample mixer
// Field widths, voice pool size, mix arithmetic constants, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int VOICES       = 8;
  localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MEMORY_WORDS = 65536;
  localparam int MEM_AW       = $clog2(MEMORY_WORDS);

  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 16;
  localparam int WORD_W  = 16;
  localparam int ID_W    = 8;
  localparam int LEN_W   = 17;
  localparam int GAIN_W  = 16;
  localparam int ACT_W   = 4;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  // mix arithmetic: word (Q1.15) * gain (Q4.12) gives units of 2^-27
  localparam int PROD_W    = WORD_W + GAIN_W + 1;
  localparam int ACC_W     = PROD_W + $clog2(VOICES) + 1;
  localparam int SUM_FRAC  = 27;
  localparam int UNITY_SUM = 134217728;
  localparam int CLAMP_W   = SUM_FRAC + 2;
  localparam int SCALE_W   = 16;
  localparam int OUT_SCALE = 32767;
  localparam int MIX_W     = CLAMP_W + SCALE_W;

  // RAM read, product and accumulate stages behind the last voice read
  localparam int DRAIN_CYCLES = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRIG = 2'd1,
    KIND_TICK = 2'd2
  } psm_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_TRIG_SET,
    ST_TICK_RD,
    ST_DRAIN,
    ST_CLAMP,
    ST_SCALE,
    ST_RESULT
  } psm_state_t;

  typedef struct packed {
    logic              capture;
    logic              mem_wr;
    logic              tick_issue;
    logic              scan;
    logic              scan_first;
    logic              trig_set;
    logic              fin_clamp;
    logic              fin_scale;
    logic              res_load;
    logic [VIDX_W-1:0] vidx;
  } psm_cmd_t;

  typedef struct packed {
    logic out_free;
  } psm_sts_t;

endpackage

// File: sv/psm_ram.sv
// ----------------------------------------------------------------------------
// psm_ram - generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module psm_ram #(
  parameter  int WIDTH  = 16,
  parameter  int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/psm_ctrl.sv
// ----------------------------------------------------------------------------
// psm_ctrl - sequencer of the sample mixer
// Steps load, trigger scan/commit and tick read/drain/clamp/scale,
// and hands each result to the output register.
// ----------------------------------------------------------------------------
module psm_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic [psm_pkg::KIND_W-1:0]          in_tuser,
  output logic                                in_tready,
  output psm_pkg::psm_cmd_t                   cmd,
  input  psm_pkg::psm_sts_t                   sts
);

  localparam logic [psm_pkg::VIDX_W-1:0] LAST_VOICE =
    psm_pkg::VIDX_W'(psm_pkg::VOICES - 1);
  localparam logic [psm_pkg::VIDX_W-1:0] LAST_DRAIN =
    psm_pkg::VIDX_W'(psm_pkg::DRAIN_CYCLES - 1);

  psm_pkg::psm_state_t       state_r, state_nxt;
  logic [psm_pkg::VIDX_W-1:0] cnt_r, cnt_nxt;
  logic                       accept;

  assign accept = in_tvalid && (state_r == psm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psm_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      psm_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          unique case (psm_pkg::psm_kind_t'(in_tuser))
            psm_pkg::KIND_LOAD: state_nxt = psm_pkg::ST_LOAD;
            psm_pkg::KIND_TRIG: state_nxt = psm_pkg::ST_SCAN;
            psm_pkg::KIND_TICK: state_nxt = psm_pkg::ST_TICK_RD;
            default:            state_nxt = psm_pkg::ST_RESULT;
          endcase
        end
      end
      psm_pkg::ST_LOAD: begin
        state_nxt = psm_pkg::ST_RESULT;
      end
      psm_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_VOICE) begin
          cnt_nxt   = '0;
          state_nxt = psm_pkg::ST_TRIG_SET;
        end
      end
      psm_pkg::ST_TRIG_SET: begin
        state_nxt = psm_pkg::ST_RESULT;
      end
      psm_pkg::ST_TICK_RD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_VOICE) begin
          cnt_nxt   = '0;
          state_nxt = psm_pkg::ST_DRAIN;
        end
      end
      psm_pkg::ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_DRAIN) begin
          cnt_nxt   = '0;
          state_nxt = psm_pkg::ST_CLAMP;
        end
      end
      psm_pkg::ST_CLAMP: begin
        state_nxt = psm_pkg::ST_SCALE;
      end
      psm_pkg::ST_SCALE: begin
        state_nxt = psm_pkg::ST_RESULT;
      end
      psm_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          state_nxt = psm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psm_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready      = (state_r == psm_pkg::ST_IDLE);
    cmd            = '0;
    cmd.vidx       = cnt_r;
    cmd.capture    = accept;
    cmd.mem_wr     = (state_r == psm_pkg::ST_LOAD);
    cmd.scan       = (state_r == psm_pkg::ST_SCAN);
    cmd.scan_first = (state_r == psm_pkg::ST_SCAN) && (cnt_r == '0);
    cmd.trig_set   = (state_r == psm_pkg::ST_TRIG_SET);
    cmd.tick_issue = (state_r == psm_pkg::ST_TICK_RD);
    cmd.fin_clamp  = (state_r == psm_pkg::ST_CLAMP);
    cmd.fin_scale  = (state_r == psm_pkg::ST_SCALE);
    cmd.res_load   = (state_r == psm_pkg::ST_RESULT) && sts.out_free;
  end

endmodule

// File: sv/psm_dpath.sv
// ----------------------------------------------------------------------------
// psm_dpath - datapath of the sample mixer
// Input register, voice pool registers, voice choice scan, sample RAM,
// multiply-accumulate pipeline, clamp/scale and the output register.
// ----------------------------------------------------------------------------
module psm_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [psm_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [psm_pkg::KIND_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [psm_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  psm_pkg::psm_cmd_t                   cmd,
  output psm_pkg::psm_sts_t                   sts
);

  localparam int VN = psm_pkg::VOICES;

  localparam logic signed [psm_pkg::ACC_W-1:0] POS_LIM =
    psm_pkg::ACC_W'(psm_pkg::UNITY_SUM);
  localparam logic signed [psm_pkg::ACC_W-1:0] NEG_LIM = -POS_LIM;
  localparam logic signed [psm_pkg::SCALE_W-1:0] SCALE_K =
    psm_pkg::SCALE_W'(psm_pkg::OUT_SCALE);
  localparam logic signed [psm_pkg::MIX_W-1:0] RND_BIAS =
    psm_pkg::MIX_W'(psm_pkg::UNITY_SUM - 1);

  // captured item
  logic [psm_pkg::KIND_W-1:0] in_kind_r;
  logic [psm_pkg::ADDR_W-1:0] in_addr_r;
  logic [psm_pkg::WORD_W-1:0] in_word_r;
  logic [psm_pkg::ID_W-1:0]   in_id_r;
  logic [psm_pkg::LEN_W-1:0]  in_len_r;
  logic [psm_pkg::GAIN_W-1:0] in_gain_r;

  // voice pool
  logic [VN-1:0]              v_act_r,   v_act_nxt;
  logic [psm_pkg::ID_W-1:0]   v_id_r     [VN];
  logic [psm_pkg::ID_W-1:0]   v_id_nxt   [VN];
  logic [psm_pkg::ADDR_W-1:0] v_start_r  [VN];
  logic [psm_pkg::ADDR_W-1:0] v_start_nxt[VN];
  logic [psm_pkg::LEN_W-1:0]  v_len_r    [VN];
  logic [psm_pkg::LEN_W-1:0]  v_len_nxt  [VN];
  logic [psm_pkg::LEN_W-1:0]  v_pos_r    [VN];
  logic [psm_pkg::LEN_W-1:0]  v_pos_nxt  [VN];
  logic [psm_pkg::GAIN_W-1:0] v_gain_r   [VN];
  logic [psm_pkg::GAIN_W-1:0] v_gain_nxt [VN];

  // voice choice scan
  logic                        m_found_r, f_found_r;
  logic [psm_pkg::VIDX_W-1:0]  m_idx_r, f_idx_r, best_idx_r, chosen;
  logic [psm_pkg::LEN_W-1:0]   least_r, rem;
  logic                        cur_match, cur_free;

  // memory and mix pipeline
  logic                          mem_we;
  logic [psm_pkg::MEM_AW-1:0]    mem_addr;
  logic [psm_pkg::LEN_W:0]       rd_sum;
  logic [psm_pkg::WORD_W-1:0]    mem_rdata;
  logic                          rd_v_r, prod_v_r;
  logic [psm_pkg::GAIN_W-1:0]    rd_gain_r;
  logic signed [psm_pkg::WORD_W-1:0] rd_word;
  logic signed [psm_pkg::GAIN_W:0]   rd_gain_s;
  logic signed [psm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [psm_pkg::ACC_W-1:0]  acc_r;
  logic signed [psm_pkg::CLAMP_W-1:0] clamp_r;
  logic                               clip_r;
  logic signed [psm_pkg::MIX_W-1:0]   mul_r, mul_nxt, biased, quot;

  // result
  logic                          out_valid_r;
  logic [psm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [psm_pkg::ACT_W-1:0]     act_cnt;
  logic [psm_pkg::WORD_W-1:0]    res_mixed;
  logic [psm_pkg::VIDX_W-1:0]    res_vidx;
  logic [2:0]                    res_vidx3;
  logic                          res_status, res_clip, is_trig, is_tick, len_zero;

  assign len_zero = (in_len_r == '0);
  assign is_trig  = (in_kind_r == psm_pkg::KIND_TRIG);
  assign is_tick  = (in_kind_r == psm_pkg::KIND_TICK);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind_r <= in_tuser;
      in_addr_r <= in_tdata[15:0];
      in_word_r <= in_tdata[31:16];
      in_id_r   <= in_tdata[39:32];
      in_len_r  <= in_tdata[56:40];
      in_gain_r <= in_tdata[72:57];
    end
  end

  // voice choice: retrigger match, else first free, else least remaining
  assign cur_match = v_act_r[cmd.vidx] && (v_id_r[cmd.vidx] == in_id_r);
  assign cur_free  = !v_act_r[cmd.vidx];
  assign rem = (v_len_r[cmd.vidx] > v_pos_r[cmd.vidx]) ?
               (v_len_r[cmd.vidx] - v_pos_r[cmd.vidx]) : '0;
  assign chosen = m_found_r ? m_idx_r : (f_found_r ? f_idx_r : best_idx_r);

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (cmd.scan_first) begin
        m_found_r  <= cur_match;
        m_idx_r    <= cmd.vidx;
        f_found_r  <= cur_free;
        f_idx_r    <= cmd.vidx;
        least_r    <= rem;
        best_idx_r <= cmd.vidx;
      end else begin
        if (!m_found_r && cur_match) begin
          m_found_r <= 1'b1;
          m_idx_r   <= cmd.vidx;
        end
        if (!f_found_r && cur_free) begin
          f_found_r <= 1'b1;
          f_idx_r   <= cmd.vidx;
        end
        if (rem < least_r) begin
          least_r    <= rem;
          best_idx_r <= cmd.vidx;
        end
      end
    end
  end

  // voice pool update: advance/retire on tick read, load on trigger commit
  always_comb begin
    logic [psm_pkg::LEN_W-1:0] pos_inc;
    v_act_nxt   = v_act_r;
    v_id_nxt    = v_id_r;
    v_start_nxt = v_start_r;
    v_len_nxt   = v_len_r;
    v_pos_nxt   = v_pos_r;
    v_gain_nxt  = v_gain_r;
    pos_inc     = v_pos_r[cmd.vidx] + 1'b1;
    if (cmd.tick_issue && v_act_r[cmd.vidx]) begin
      v_pos_nxt[cmd.vidx] = pos_inc;
      if (pos_inc >= v_len_r[cmd.vidx]) begin
        v_act_nxt[cmd.vidx] = 1'b0;
      end
    end
    if (cmd.trig_set && !len_zero) begin
      v_act_nxt[chosen]   = 1'b1;
      v_id_nxt[chosen]    = in_id_r;
      v_start_nxt[chosen] = in_addr_r;
      v_len_nxt[chosen]   = in_len_r;
      v_pos_nxt[chosen]   = '0;
      v_gain_nxt[chosen]  = in_gain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_act_r <= '0;
      for (int i = 0; i < VN; i++) begin
        v_id_r[i]    <= '0;
        v_start_r[i] <= '0;
        v_len_r[i]   <= '0;
        v_pos_r[i]   <= '0;
        v_gain_r[i]  <= '0;
      end
    end else begin
      v_act_r   <= v_act_nxt;
      v_id_r    <= v_id_nxt;
      v_start_r <= v_start_nxt;
      v_len_r   <= v_len_nxt;
      v_pos_r   <= v_pos_nxt;
      v_gain_r  <= v_gain_nxt;
    end
  end

  // sample memory
  assign mem_we = cmd.mem_wr;
  assign rd_sum = (psm_pkg::LEN_W+1)'(v_start_r[cmd.vidx]) +
                  (psm_pkg::LEN_W+1)'(v_pos_r[cmd.vidx]);
  assign mem_addr = cmd.mem_wr ? psm_pkg::MEM_AW'(in_addr_r) :
                                 psm_pkg::MEM_AW'(rd_sum);

  psm_ram #(
    .WIDTH (psm_pkg::WORD_W),
    .DEPTH (psm_pkg::MEMORY_WORDS)
  ) u_sample_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_word_r),
    .rdata (mem_rdata)
  );

  // multiply-accumulate pipeline
  assign rd_word   = mem_rdata;
  assign rd_gain_s = {1'b0, rd_gain_r};
  assign prod_nxt  = rd_word * rd_gain_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.tick_issue && v_act_r[cmd.vidx];
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_gain_r <= v_gain_r[cmd.vidx];
    prod_r    <= prod_nxt;
    if (cmd.capture) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + psm_pkg::ACC_W'(prod_r);
    end
  end

  // clamp to +-1.0, scale by 32767/32768 truncating toward zero
  assign mul_nxt = clamp_r * SCALE_K;
  assign biased  = mul_r + (mul_r[psm_pkg::MIX_W-1] ? RND_BIAS : '0);
  assign quot    = biased >>> psm_pkg::SUM_FRAC;

  always_ff @(posedge clk) begin
    if (cmd.fin_clamp) begin
      priority if (acc_r > POS_LIM) begin
        clamp_r <= psm_pkg::CLAMP_W'(POS_LIM);
        clip_r  <= 1'b1;
      end else if (acc_r < NEG_LIM) begin
        clamp_r <= psm_pkg::CLAMP_W'(NEG_LIM);
        clip_r  <= 1'b1;
      end else begin
        clamp_r <= psm_pkg::CLAMP_W'(acc_r);
        clip_r  <= 1'b0;
      end
    end
    if (cmd.fin_scale) begin
      mul_r <= mul_nxt;
    end
  end

  // result fields
  always_comb begin
    act_cnt = '0;
    for (int i = 0; i < VN; i++) begin
      act_cnt = act_cnt + psm_pkg::ACT_W'(v_act_r[i]);
    end
  end

  assign res_mixed  = is_tick ? psm_pkg::WORD_W'(quot) : '0;
  assign res_vidx   = (is_trig && !len_zero) ? chosen : '0;
  assign res_vidx3  = 3'(res_vidx);
  assign res_status = is_trig && len_zero;
  assign res_clip   = is_tick && clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= psm_pkg::OUT_DATA_W'({act_cnt, res_clip, res_status,
                                          res_vidx3, res_mixed});
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

// File: sv/polyphonic_sample_mixer.sv
// ----------------------------------------------------------------------------
// polyphonic_sample_mixer - fixed voice pool sample player and mixer
// Loads sample words, assigns voices on trigger (retrigger, free, steal)
// and mixes one clamped, scaled output sample per tick.
//
//   channel  direction  handshake          payload
//   in_      slave      tvalid/tready      tdata 80 b, tuser 2 b (kind)
//   out_     master     tvalid/tready      tdata 32 b
//
// Trigger and tick items step through the voice pool one voice per cycle,
// a tick reading each voice's sample through the single RAM port.
// A result waits in the output register; the next item is taken meanwhile,
// and its result step waits until the previous one has gone.
// Reset (synchronous, rst_n low) empties the voice pool; sample memory
// holds nothing defined until written and is not cleared.
// ----------------------------------------------------------------------------
module polyphonic_sample_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // address[15:0], word_value[31:16], sample_id[39:32],
  // sample_length[56:40], gain[72:57], zero[79:73]
  input  logic [psm_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [psm_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // mixed_sample[15:0], voice_index[18:16], status[19], clipped[20],
  // active_count[24:21], zero[31:25]
  output logic [psm_pkg::OUT_DATA_W-1:0] out_tdata
);

  psm_pkg::psm_cmd_t cmd;
  psm_pkg::psm_sts_t sts;

  psm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  psm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
